// ----- design/mne_pkg.sv -----
// shared types and codes for the markup nesting enforcer
`timescale 1ns / 1ps
`default_nettype none

package mne_pkg;

  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

  localparam logic [3:0] REQ_CHAR       = 4'd0;
  localparam logic [3:0] REQ_END        = 4'd1;
  localparam logic [3:0] REQ_CODE       = 4'd2;
  localparam logic [3:0] REQ_HEADER     = 4'd3;
  localparam logic [3:0] REQ_PARA       = 4'd4;
  localparam logic [3:0] REQ_QUOTE      = 4'd5;
  localparam logic [3:0] REQ_TOGGLE     = 4'd6;
  localparam logic [3:0] REQ_CLOSE_LINK = 4'd7;
  localparam logic [3:0] REQ_IMAGE      = 4'd8;
  localparam logic [3:0] REQ_RULE       = 4'd9;

  localparam logic [2:0] MOD_LINK = 3'd2;
  localparam logic [2:0] MOD_MAX  = 3'd5;

  localparam logic [2:0] BLK_NONE   = 3'd0;
  localparam logic [2:0] BLK_CODE   = 3'd1;
  localparam logic [2:0] BLK_HEADER = 3'd2;
  localparam logic [2:0] BLK_PARA   = 3'd3;
  localparam logic [2:0] BLK_QUOTE  = 3'd4;

  localparam logic [2:0] EV_CHAR      = 3'd0;
  localparam logic [2:0] EV_OPEN_BLK  = 3'd1;
  localparam logic [2:0] EV_CLOSE_BLK = 3'd2;
  localparam logic [2:0] EV_OPEN_MOD  = 3'd3;
  localparam logic [2:0] EV_CLOSE_MOD = 3'd4;
  localparam logic [2:0] EV_IMAGE     = 3'd5;
  localparam logic [2:0] EV_RULE      = 3'd6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_CLOSE_TOP,
    OP_CLOSE_BLK,
    OP_OPEN_BLK,
    OP_OPEN_PARA,
    OP_CHAR,
    OP_IMAGE,
    OP_RULE,
    OP_PUSH,
    OP_TCLOSE,
    OP_TOPEN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] req;
    logic       mod_ok;
    logic       found;
    logic       count_zero;
    logic       count_one;
    logic       full;
    logic       cur_open;
    logic       at_idx;
    logic       at_top;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/mne_ctrl.sv -----
// sequencing state machine for the markup nesting enforcer
`timescale 1ns / 1ps
`default_nettype none

module mne_ctrl
  import mne_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_DISPATCH   = 9'b000000010,
    S_ENSURE     = 9'b000000100,
    S_ACTION     = 9'b000001000,
    S_CLOSE_MODS = 9'b000010000,
    S_CLOSE_BLK  = 9'b000100000,
    S_OPEN_BLK   = 9'b001000000,
    S_TCLOSE     = 9'b010000000,
    S_TOPEN      = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   is_end, is_blk, is_text, is_toggle;

  assign is_end    = sts.req == REQ_END;
  assign is_blk    = is_end || sts.req == REQ_CODE || sts.req == REQ_HEADER ||
                     sts.req == REQ_PARA || sts.req == REQ_QUOTE;
  assign is_text   = sts.req == REQ_CHAR || sts.req == REQ_IMAGE || sts.req == REQ_RULE;
  assign is_toggle = sts.req == REQ_TOGGLE;

  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.op     = OP_PREP;
        state_next = S_IDLE;
        if (is_text) begin
          state_next = sts.cur_open ? S_ACTION : S_ENSURE;
        end else if (is_blk) begin
          if (!sts.count_zero) begin
            state_next = S_CLOSE_MODS;
          end else if (sts.cur_open) begin
            state_next = S_CLOSE_BLK;
          end else if (!is_end) begin
            state_next = S_OPEN_BLK;
          end
        end else if (is_toggle && sts.mod_ok) begin
          if (sts.found) begin
            state_next = S_TCLOSE;
          end else if (!sts.cur_open) begin
            state_next = S_ENSURE;
          end else if (!sts.full) begin
            state_next = S_ACTION;
          end
        end else if (sts.req == REQ_CLOSE_LINK && sts.found) begin
          state_next = S_TCLOSE;
        end
      end
      S_ENSURE: begin
        if (sts.out_free) begin
          cmd.op     = OP_OPEN_PARA;
          cmd.last   = is_toggle && sts.full;
          state_next = (is_toggle && sts.full) ? S_IDLE : S_ACTION;
        end
      end
      S_ACTION: begin
        if (sts.out_free) begin
          case (sts.req)
            REQ_CHAR:  cmd.op = OP_CHAR;
            REQ_IMAGE: cmd.op = OP_IMAGE;
            REQ_RULE:  cmd.op = OP_RULE;
            default:   cmd.op = OP_PUSH;
          endcase
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLOSE_MODS: begin
        if (sts.out_free) begin
          cmd.op   = OP_CLOSE_TOP;
          cmd.last = sts.count_one && !sts.cur_open && is_end;
          if (sts.count_one) begin
            if (sts.cur_open) begin
              state_next = S_CLOSE_BLK;
            end else begin
              state_next = is_end ? S_IDLE : S_OPEN_BLK;
            end
          end
        end
      end
      S_CLOSE_BLK: begin
        if (sts.out_free) begin
          cmd.op     = OP_CLOSE_BLK;
          cmd.last   = is_end;
          state_next = is_end ? S_IDLE : S_OPEN_BLK;
        end
      end
      S_OPEN_BLK: begin
        if (sts.out_free) begin
          cmd.op     = OP_OPEN_BLK;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TCLOSE: begin
        if (sts.out_free) begin
          cmd.op   = OP_TCLOSE;
          cmd.last = sts.at_idx && sts.at_top;
          if (sts.at_idx) begin
            state_next = sts.at_top ? S_IDLE : S_TOPEN;
          end
        end
      end
      S_TOPEN: begin
        if (sts.out_free) begin
          cmd.op   = OP_TOPEN;
          cmd.last = sts.at_top;
          if (sts.at_top) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/mne_dp.sv -----
// block state, modifier stack and output register of the markup nesting enforcer
`timescale 1ns / 1ps
`default_nettype none

module mne_dp
  import mne_pkg::*;
#(
  parameter int STACK_DEPTH = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tlast
);

  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [3:0]    req_type;
  logic [2:0]    req_mod;
  logic [2:0]    req_lvl;
  logic [7:0]    req_ch;
  logic [15:0]   req_h;

  logic [2:0]    cur_block;
  logic [2:0]    block_level;
  logic [CW-1:0] count;
  logic [15:0]   link_handle;
  logic [IW-1:0] ptr;
  logic [IW-1:0] idx;
  logic [2:0]    stack [STACK_DEPTH];

  logic [2:0]    out_ev, out_blk, out_lvl, out_mod;
  logic [7:0]    out_ch;
  logic [15:0]   out_h;

  logic          emit;
  logic [2:0]    ev_n, blk_n, lvl_n, mod_n;
  logic [7:0]    ch_n;
  logic [15:0]   h_n;

  logic [2:0]    key;
  logic          found;
  logic [IW-1:0] found_idx;
  logic [2:0]    top_mod;
  logic [15:0]   mod_handle;
  logic [2:0]    open_kind;
  logic          out_free;

  assign key = (req_type == REQ_CLOSE_LINK) ? MOD_LINK : req_mod;

  // topmost match wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = 0; j < STACK_DEPTH; j++) begin
      if (CW'(j) < count && stack[j] == key) begin
        found     = 1'b1;
        found_idx = IW'(j);
      end
    end
  end

  assign top_mod    = stack[ptr];
  assign mod_handle = (top_mod == MOD_LINK) ? link_handle : 16'd0;
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    case (req_type)
      REQ_CODE:   open_kind = BLK_CODE;
      REQ_HEADER: open_kind = BLK_HEADER;
      REQ_QUOTE:  open_kind = BLK_QUOTE;
      default:    open_kind = BLK_PARA;
    endcase
  end

  assign sts.req        = req_type;
  assign sts.mod_ok     = req_mod <= MOD_MAX;
  assign sts.found      = found;
  assign sts.count_zero = count == '0;
  assign sts.count_one  = count == CW'(1);
  assign sts.full       = count >= CW'(STACK_DEPTH);
  assign sts.cur_open   = cur_block != BLK_NONE;
  assign sts.at_idx     = ptr == idx;
  assign sts.at_top     = CW'(ptr) == count - CW'(1);
  assign sts.out_free   = out_free;

  always_comb begin
    emit  = 1'b1;
    ev_n  = EV_CHAR;
    blk_n = BLK_NONE;
    lvl_n = 3'd0;
    mod_n = 3'd0;
    ch_n  = 8'd0;
    h_n   = 16'd0;
    case (cmd.op)
      OP_CLOSE_TOP, OP_TCLOSE: begin
        ev_n  = EV_CLOSE_MOD;
        mod_n = top_mod;
        h_n   = mod_handle;
      end
      OP_TOPEN: begin
        ev_n  = EV_OPEN_MOD;
        mod_n = top_mod;
        h_n   = mod_handle;
      end
      OP_CLOSE_BLK: begin
        ev_n  = EV_CLOSE_BLK;
        blk_n = cur_block;
        lvl_n = (cur_block == BLK_HEADER) ? block_level : 3'd0;
      end
      OP_OPEN_BLK: begin
        ev_n  = EV_OPEN_BLK;
        blk_n = open_kind;
        lvl_n = (open_kind == BLK_HEADER) ? req_lvl : 3'd0;
      end
      OP_OPEN_PARA: begin
        ev_n  = EV_OPEN_BLK;
        blk_n = BLK_PARA;
      end
      OP_CHAR: begin
        ch_n = req_ch;
      end
      OP_IMAGE: begin
        ev_n = EV_IMAGE;
        h_n  = req_h;
      end
      OP_RULE: begin
        ev_n = EV_RULE;
      end
      OP_PUSH: begin
        ev_n  = EV_OPEN_MOD;
        mod_n = req_mod;
        h_n   = (req_mod == MOD_LINK) ? req_h : 16'd0;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_block   <= BLK_NONE;
      block_level <= 3'd0;
      count       <= '0;
      link_handle <= 16'd0;
      m_tvalid    <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        OP_CLOSE_TOP: count <= count - CW'(1);
        OP_CLOSE_BLK: begin
          if (req_type == REQ_END) begin
            cur_block <= BLK_NONE;
          end
        end
        OP_OPEN_BLK: begin
          cur_block   <= open_kind;
          block_level <= lvl_n;
        end
        OP_OPEN_PARA: begin
          cur_block   <= BLK_PARA;
          block_level <= 3'd0;
        end
        OP_PUSH: begin
          if (req_mod == MOD_LINK) begin
            link_handle <= req_h;
          end
          count <= count + CW'(1);
        end
        OP_TCLOSE: begin
          if (ptr == idx) begin
            count <= count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ev  <= ev_n;
      out_blk <= blk_n;
      out_lvl <= lvl_n;
      out_mod <= mod_n;
      out_ch  <= ch_n;
      out_h   <= h_n;
      m_tlast <= cmd.last;
    end
    case (cmd.op)
      OP_LOAD: begin
        req_type <= s_tdata[3:0];
        req_mod  <= s_tdata[6:4];
        req_lvl  <= s_tdata[9:7];
        req_ch   <= s_tdata[17:10];
        req_h    <= s_tdata[33:18];
      end
      OP_PREP: begin
        ptr <= IW'(count - CW'(1));
        idx <= found_idx;
      end
      OP_CLOSE_TOP: ptr <= ptr - IW'(1);
      OP_PUSH:      stack[IW'(count)] <= req_mod;
      OP_TCLOSE: begin
        if (ptr == idx) begin
          // drop the toggled entry, modifiers above slide down
          for (int j = 0; j < STACK_DEPTH - 1; j++) begin
            if (IW'(j) >= idx) begin
              stack[j] <= stack[j + 1];
            end
          end
        end else begin
          ptr <= ptr - IW'(1);
        end
      end
      OP_TOPEN: ptr <= ptr + IW'(1);
      default: ;
    endcase
  end

  assign m_tdata = {4'd0, out_h, out_ch, out_mod, out_lvl, out_blk, out_ev};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("modifier count above stack depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PUSH |=> count == $past(count) + CW'(1))
    else $error("push did not grow the stack");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("item written over a waiting result");

  a_reopen_below_top: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_TOPEN |-> CW'(ptr) < count)
    else $error("reopen beyond stack top");

endmodule

`default_nettype wire

// ----- design/markup_nesting_enforcer.sv -----
// Markup nesting enforcer top level.
// Input stream s_*: one markup request per item (char, end, block, toggle of a
// modifier, close link, image, rule). Output stream m_*: open/close, char, image
// and rule events in properly nested order; m_tlast marks the final event that
// a request causes. A request that causes no event gives no output at all.
// Sequencing: a request is taken only while the sequencer is idle; it is decoded
// in the next cycle, and its events then go one by one into the output
// register, one event per cycle while that register is free. A request causes
// up to N events, N the larger of 2*STACK_DEPTH-1 and STACK_DEPTH+2 (11 at
// the default), set by the walk of the modifier stack.
// The output register lets the next request be taken while the last event of
// the previous one still waits. When the receiver stalls, the walk pauses and
// no event is lost or repeated.
// Reset: no block open, modifier stack empty, stored link handle zero.
`timescale 1ns / 1ps
`default_nettype none

module markup_nesting_enforcer
  import mne_pkg::*;
#(
  parameter int STACK_DEPTH = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // req_type[3:0], mod_id[6:4], hdr_level[9:7], char_code[17:10],
  // ref_handle[33:18], zero fill
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // event_res[2:0], block_kind[5:3], level_out[8:6], mod_out[11:9],
  // char_out[19:12], handle_out[35:20], zero fill
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tlast
);

  cmd_t cmd;
  sts_t sts;

  mne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mne_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
